>>> hdl/ufs_pkg.sv
// Shared types, constants and helper functions of the UDP flow selector.
package ufs_pkg;

   localparam int FLOWS_MAX_DEFAULT = 256;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int NFLOWS_W   = 9;
   localparam int BURST_W    = 16;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USED_W = 76;

   localparam logic [15:0] PORT_MOD = 16'hFFFF;

   localparam int MOD_DVD_W     = 32;
   localparam int MOD_STEP_BITS = 4;
   localparam int MOD_STEPS     = MOD_DVD_W / MOD_STEP_BITS;
   localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

   localparam logic REQ_GENERATE = 1'b0;
   localparam logic REQ_CLEAR    = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ACTIVE,
      CSR_SEQ_MODE,
      CSR_FLOWS_IN_USE,
      CSR_FLOW_SIZE,
      CSR_FLOW_BURST,
      CSR_PACKET_LIMIT,
      CSR_LIMIT_EN,
      CSR_STOP_AT_LIMIT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MOD,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [31:0] count;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } entry_type;

   typedef struct packed {
      logic [31:0] packet_count;
      logic        stop_request;
      logic        limit_reached;
      logic        ports_changed;
      logic [15:0] dst_port;
      logic [15:0] src_port;
      logic [7:0]  flow_index;
      logic        emitted;
   } result_type;

   function automatic logic [15:0] port_seq(input logic [15:0] old);
      logic [16:0] v;
      v = {1'b0, old} + 17'd1;
      if (v >= 17'(PORT_MOD)) begin
         v = v - 17'(PORT_MOD);
      end
      return v[15:0];
   endfunction

   function automatic logic [15:0] port_rand(input logic [31:0] rnd);
      logic [29:0] x;
      logic [16:0] s;
      logic [16:0] t;
      x = rnd[31:2];
      s = 17'(x[29:16]) + 17'(x[15:0]);
      t = 17'(s[16]) + 17'(s[15:0]);
      if (t >= 17'(PORT_MOD)) begin
         t = t - 17'(PORT_MOD);
      end
      return t[15:0];
   endfunction

endpackage

>>> hdl/ufs_mod_unit.sv
// Iterative remainder unit, four dividend bits per cycle, for the flow selection.
module ufs_mod_unit #(
   parameter int FLOWS_MAX = ufs_pkg::FLOWS_MAX_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [ufs_pkg::MOD_DVD_W-1:0]        dividend,
   input  logic [$clog2(FLOWS_MAX+1)-1:0]       divisor,
   output logic                                 done,
   output logic [$clog2(FLOWS_MAX+1)-1:0]       remainder
);

   localparam int N_W = $clog2(FLOWS_MAX + 1);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [ufs_pkg::MOD_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ufs_pkg::MOD_DVD_W-1:0]     dvd_ff, dvd_in;
   logic [N_W-1:0]                    div_ff, div_in;
   logic [N_W-1:0]                    rem_ff, rem_in;
   logic [N_W:0]                      part;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      part    = {1'b0, rem_ff};
      for (int i = 0; i < ufs_pkg::MOD_STEP_BITS; i++) begin
         part = {part[N_W-1:0], dvd_ff[ufs_pkg::MOD_DVD_W-1-i]};
         if (part >= {1'b0, div_ff}) begin
            part = part - {1'b0, div_ff};
         end
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = part[N_W-1:0];
         dvd_in = dvd_ff << ufs_pkg::MOD_STEP_BITS;
         cnt_in = cnt_ff + ufs_pkg::MOD_CNT_W'(1);
         if (cnt_ff == ufs_pkg::MOD_CNT_W'(ufs_pkg::MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> hdl/ufs_flow_table.sv
// Per-flow state memory with a clearing pass after reset.
module ufs_flow_table #(
   parameter int FLOWS_MAX = ufs_pkg::FLOWS_MAX_DEFAULT
) (
   input  logic                                            clock,
   input  logic                                            reset,
   output logic                                            ready,
   input  logic                                            rd_en,
   input  logic [((FLOWS_MAX > 1) ? $clog2(FLOWS_MAX) : 1)-1:0] rd_addr,
   output ufs_pkg::entry_type                              rd_data,
   input  logic                                            wr_en,
   input  logic [((FLOWS_MAX > 1) ? $clog2(FLOWS_MAX) : 1)-1:0] wr_addr,
   input  ufs_pkg::entry_type                              wr_data
);

   localparam int FLOW_W = (FLOWS_MAX > 1) ? $clog2(FLOWS_MAX) : 1;

   ufs_pkg::entry_type  mem [FLOWS_MAX];
   ufs_pkg::entry_type  rd_data_ff;
   logic                clearing_ff, clearing_in;
   logic [FLOW_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                mem_we;
   logic [FLOW_W-1:0]   mem_addr;
   ufs_pkg::entry_type  mem_wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      mem_we      = wr_en;
      mem_addr    = wr_addr;
      mem_wdata   = wr_data;
      if (clearing_ff) begin
         mem_we      = 1'b1;
         mem_addr    = clr_addr_ff;
         mem_wdata   = '0;
         clr_addr_in = clr_addr_ff + FLOW_W'(1);
         if (clr_addr_ff == FLOW_W'(FLOWS_MAX - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign ready   = !clearing_ff;
   assign rd_data = rd_data_ff;

endmodule

>>> hdl/udp_flow_selector_core.sv
// Top level of the UDP flow selector: control, configuration and result register.
//
// Each request transfer on the req_ channel is one packet slot (tuser low) or a
// clear of the packet count (tuser high); tdata carries the three random words.
// Every request gives exactly one response transfer on the rsp_ channel with the
// chosen flow, its port pair, the renewal flag, the limit state and the count.
// Configuration is written through csr_we, csr_addr and csr_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// For a generate slot the flow index comes from an iterative remainder unit
// that handles four bits of its 32-bit dividend per cycle; then the flow entry
// is read from the per-flow memory, renewed (or its count raised) and written
// back, and the response is loaded. Clears and blocked slots go straight to
// the response. One request is handled at a time; the next one is taken while
// the previous response still waits in the output register.
// After reset the per-flow memory is cleared, one entry per cycle, and
// req_tready stays low meanwhile. Configuration registers return to their
// defaults at reset. When the receiver stalls, the response holds and at
// most one further finished item waits inside the block.
module udp_flow_selector_core #(
   parameter int FLOWS_MAX = ufs_pkg::FLOWS_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Bits from low: rand_flow[31:0], rand_src[63:32], rand_dst[95:64].
   input  logic [ufs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Bits from low: req_type.
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Bits from low: emitted, flow_index[8:1], src_port[24:9], dst_port[40:25],
   // ports_changed[41], limit_reached[42], stop_request[43],
   // packet_count[75:44], zero padding[79:76].
   output logic [ufs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [ufs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ufs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int FLOW_W = (FLOWS_MAX > 1) ? $clog2(FLOWS_MAX) : 1;
   localparam int N_W    = $clog2(FLOWS_MAX + 1);
   localparam int CMP_W  = (N_W > ufs_pkg::NFLOWS_W) ? N_W : ufs_pkg::NFLOWS_W;

   logic                               active_ff;
   logic                               seq_ff;
   logic [ufs_pkg::NFLOWS_W-1:0]       nflows_ff;
   logic [31:0]                        flow_size_ff;
   logic [ufs_pkg::BURST_W-1:0]        burst_len_ff;
   logic [31:0]                        limit_ff;
   logic                               limit_en_ff;
   logic                               stop_en_ff;

   ufs_pkg::state_type                 state_ff, state_in;
   logic [31:0]                        sent_ff, sent_in;
   logic [ufs_pkg::BURST_W-1:0]        burst_ff, burst_in;
   logic [FLOW_W-1:0]                  next_flow_ff, next_flow_in;
   logic [FLOW_W-1:0]                  flow_ff, flow_in;
   logic                               reselect_ff, reselect_in;
   logic                               req_type_ff;
   logic [31:0]                        rand_flow_ff, rand_src_ff, rand_dst_ff;
   ufs_pkg::result_type                res_ff, res_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ufs_pkg::result_type                rsp_data_ff, rsp_data_in;

   logic                               req_take;
   logic                               rsp_load;
   logic                               limit_hit_cur;
   logic                               reselect_now;
   logic [CMP_W-1:0]                   nflows_ext;
   logic [CMP_W-1:0]                   n_sel;
   logic [N_W-1:0]                     n_eff;
   logic [N_W-1:0]                     flow_plus;
   logic [FLOW_W+7:0]                  flow_wide;
   logic [31:0]                        sent_next;
   logic                               renew;

   logic                               mod_start;
   logic [ufs_pkg::MOD_DVD_W-1:0]      mod_dividend;
   logic                               mod_done;
   logic [N_W-1:0]                     mod_rem;

   logic                               tbl_ready;
   logic                               tbl_rd_en;
   logic [FLOW_W-1:0]                  tbl_rd_addr;
   ufs_pkg::entry_type                 tbl_rd_data;
   logic                               tbl_wr_en;
   ufs_pkg::entry_type                 tbl_wr_data;

   ufs_mod_unit #(
      .FLOWS_MAX (FLOWS_MAX)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (n_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   ufs_flow_table #(
      .FLOWS_MAX (FLOWS_MAX)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .ready   (tbl_ready),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data),
      .wr_en   (tbl_wr_en),
      .wr_addr (flow_ff),
      .wr_data (tbl_wr_data)
   );

   assign req_tready = (state_ff == ufs_pkg::ST_IDLE) && tbl_ready;
   assign req_take   = req_tvalid && req_tready;

   assign nflows_ext = CMP_W'(nflows_ff);
   always_comb begin
      if (nflows_ff == '0) begin
         n_sel = CMP_W'(1);
      end else if (nflows_ext > CMP_W'(FLOWS_MAX)) begin
         n_sel = CMP_W'(FLOWS_MAX);
      end else begin
         n_sel = nflows_ext;
      end
   end
   assign n_eff = n_sel[N_W-1:0];

   assign limit_hit_cur = limit_en_ff && (sent_ff >= limit_ff);
   assign reselect_now  = !(burst_ff < burst_len_ff);
   assign mod_dividend  = (reselect_now && !seq_ff) ? {2'b00, rand_flow_ff[31:2]}
                                                    : ufs_pkg::MOD_DVD_W'(next_flow_ff);
   assign flow_plus     = mod_rem + N_W'(1);
   assign flow_wide     = (FLOW_W + 8)'(flow_ff);
   assign sent_next     = sent_ff + 32'd1;
   assign renew         = tbl_rd_data.count >= flow_size_ff;

   always_comb begin
      state_in     = state_ff;
      sent_in      = sent_ff;
      burst_in     = burst_ff;
      next_flow_in = next_flow_ff;
      flow_in      = flow_ff;
      reselect_in  = reselect_ff;
      res_in       = res_ff;
      mod_start    = 1'b0;
      tbl_rd_en    = 1'b0;
      tbl_rd_addr  = mod_rem[FLOW_W-1:0];
      tbl_wr_en    = 1'b0;
      tbl_wr_data  = tbl_rd_data;
      rsp_load     = 1'b0;
      case (state_ff)
         ufs_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = ufs_pkg::ST_DECIDE;
            end
         end
         ufs_pkg::ST_DECIDE: begin
            res_in = '0;
            if (req_type_ff == ufs_pkg::REQ_CLEAR) begin
               sent_in              = '0;
               res_in.limit_reached = limit_en_ff && (limit_ff == '0);
               res_in.packet_count  = '0;
               state_in             = ufs_pkg::ST_RESULT;
            end else if (!active_ff || limit_hit_cur) begin
               res_in.limit_reached = limit_hit_cur;
               res_in.packet_count  = sent_ff;
               state_in             = ufs_pkg::ST_RESULT;
            end else begin
               mod_start   = 1'b1;
               reselect_in = reselect_now;
               burst_in    = reselect_now ? ufs_pkg::BURST_W'(1)
                                          : burst_ff + ufs_pkg::BURST_W'(1);
               state_in    = ufs_pkg::ST_MOD;
            end
         end
         ufs_pkg::ST_MOD: begin
            if (mod_done) begin
               flow_in   = mod_rem[FLOW_W-1:0];
               tbl_rd_en = 1'b1;
               if (reselect_ff && seq_ff) begin
                  next_flow_in = (flow_plus == n_eff) ? '0 : flow_plus[FLOW_W-1:0];
               end
               state_in = ufs_pkg::ST_UPDATE;
            end
         end
         ufs_pkg::ST_UPDATE: begin
            tbl_wr_en = 1'b1;
            if (renew) begin
               tbl_wr_data.count    = 32'd1;
               tbl_wr_data.src_port = seq_ff ? ufs_pkg::port_seq(tbl_rd_data.src_port)
                                             : ufs_pkg::port_rand(rand_src_ff);
               tbl_wr_data.dst_port = seq_ff ? ufs_pkg::port_seq(tbl_rd_data.dst_port)
                                             : ufs_pkg::port_rand(rand_dst_ff);
            end else begin
               tbl_wr_data.count = tbl_rd_data.count + 32'd1;
            end
            sent_in              = sent_next;
            res_in.emitted       = 1'b1;
            res_in.flow_index    = flow_wide[7:0];
            res_in.src_port      = tbl_wr_data.src_port;
            res_in.dst_port      = tbl_wr_data.dst_port;
            res_in.ports_changed = renew;
            res_in.limit_reached = limit_en_ff && (sent_next >= limit_ff);
            res_in.stop_request  = limit_en_ff && (sent_next >= limit_ff) && stop_en_ff;
            res_in.packet_count  = sent_next;
            state_in             = ufs_pkg::ST_RESULT;
         end
         ufs_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ufs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ufs_pkg::ST_IDLE;
         end
      endcase
      rsp_data_in  = rsp_load ? res_ff : rsp_data_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufs_pkg::ST_IDLE;
         sent_ff      <= '0;
         burst_ff     <= '0;
         next_flow_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sent_ff      <= sent_in;
         burst_ff     <= burst_in;
         next_flow_ff <= next_flow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      flow_ff     <= flow_in;
      reselect_ff <= reselect_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (req_take) begin
         req_type_ff  <= req_tuser;
         rand_flow_ff <= req_tdata[31:0];
         rand_src_ff  <= req_tdata[63:32];
         rand_dst_ff  <= req_tdata[95:64];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b1;
         seq_ff       <= 1'b0;
         nflows_ff    <= ufs_pkg::NFLOWS_W'(1);
         flow_size_ff <= 32'd1;
         burst_len_ff <= ufs_pkg::BURST_W'(1);
         limit_ff     <= '0;
         limit_en_ff  <= 1'b0;
         stop_en_ff   <= 1'b0;
      end else if (csr_we) begin
         case (ufs_pkg::csr_index_type'(csr_addr))
            ufs_pkg::CSR_ACTIVE:        active_ff    <= csr_wdata[0];
            ufs_pkg::CSR_SEQ_MODE:      seq_ff       <= csr_wdata[0];
            ufs_pkg::CSR_FLOWS_IN_USE:  nflows_ff    <= csr_wdata[ufs_pkg::NFLOWS_W-1:0];
            ufs_pkg::CSR_FLOW_SIZE:     flow_size_ff <= csr_wdata;
            ufs_pkg::CSR_FLOW_BURST:    burst_len_ff <= csr_wdata[ufs_pkg::BURST_W-1:0];
            ufs_pkg::CSR_PACKET_LIMIT:  limit_ff     <= csr_wdata;
            ufs_pkg::CSR_LIMIT_EN:      limit_en_ff  <= csr_wdata[0];
            ufs_pkg::CSR_STOP_AT_LIMIT: stop_en_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ufs_pkg::RSP_DATA_W - ufs_pkg::RSP_USED_W)'(0), rsp_data_ff};

   a_mod_done_in_mod_state: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == ufs_pkg::ST_MOD)
      else $error("remainder finished outside the flow selection state");

   a_update_counts_packet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ufs_pkg::ST_UPDATE |=> sent_ff == $past(sent_ff) + 32'd1)
      else $error("packet count did not advance on an emitted packet");

   a_transfer_starts_decide: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ufs_pkg::ST_DECIDE)
      else $error("request transfer not followed by the decision state");

   a_load_from_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> state_ff == ufs_pkg::ST_RESULT && (!rsp_valid_ff || rsp_tready))
      else $error("response register loaded while it still held a result");

endmodule
